@@ sv/morse_key_decoder_assert.svh @@
// Assertion macros for the Morse key decoder.
// Expects signals clk and arst_n in the scope of use.
`ifndef MORSE_KEY_DECODER_ASSERT_SVH
`define MORSE_KEY_DECODER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define MKD_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("morse_key_decoder: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define MKD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("morse_key_decoder: next-cycle check failed");

`endif

@@ sv/mkd_pkg.sv @@
// Shared types and constants for the Morse key decoder.
// No dependencies; used by mkd_rom, mkd_core and morse_key_decoder.
`timescale 1ns / 1ps
`default_nettype none

package mkd_pkg;

	// Width of the press and silence tick counters
	localparam int COUNT_WIDTH = 8;

	typedef logic [COUNT_WIDTH-1:0] cnt_t;

	localparam cnt_t CNT_MAX = '1;

	// Element buffer limits
	localparam logic [2:0] MAX_ELEMENTS = 3'd5;

	// Output characters that are not letters or digits
	localparam logic [6:0] CHAR_SPACE   = 7'h20;
	localparam logic [6:0] CHAR_UNKNOWN = 7'h3F;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_MIN_PRESS  = 3'd0,
		REG_DIT_MAX    = 3'd1,
		REG_LETTER_GAP = 3'd2,
		REG_SPACE_GAP  = 3'd3
	} cfg_idx_t;

	// Timing thresholds as seen by the decoder core
	typedef struct packed {
		logic [7:0] min_press;
		logic [7:0] dit_max;
		logic [7:0] letter_gap;
		logic [7:0] space_gap;
	} cfg_t;

	// One result beat
	typedef struct packed {
		logic       led;
		logic       char_valid;
		logic [6:0] char_code;
	} result_t;

endpackage

`default_nettype wire

@@ sv/mkd_rom.sv @@
// Pattern-to-ASCII lookup for letters and digits.
// Pattern is element count in bits 7..5 and elements (dash = 1) in bits 4..0.
// Depends on mkd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mkd_rom (
	input  wire logic [7:0] pattern,
	output logic      [6:0] ascii
);

	// Decode the pattern; anything unlisted is unknown
	always_comb begin
		case (pattern)
			8'h20: ascii = 7'h45; // E
			8'h30: ascii = 7'h54; // T
			8'h40: ascii = 7'h49; // I
			8'h48: ascii = 7'h41; // A
			8'h50: ascii = 7'h4E; // N
			8'h58: ascii = 7'h4D; // M
			8'h60: ascii = 7'h53; // S
			8'h64: ascii = 7'h55; // U
			8'h68: ascii = 7'h52; // R
			8'h6C: ascii = 7'h57; // W
			8'h70: ascii = 7'h44; // D
			8'h74: ascii = 7'h4B; // K
			8'h78: ascii = 7'h47; // G
			8'h7C: ascii = 7'h4F; // O
			8'h80: ascii = 7'h48; // H
			8'h82: ascii = 7'h56; // V
			8'h84: ascii = 7'h46; // F
			8'h88: ascii = 7'h4C; // L
			8'h8C: ascii = 7'h50; // P
			8'h8E: ascii = 7'h4A; // J
			8'h90: ascii = 7'h42; // B
			8'h92: ascii = 7'h58; // X
			8'h94: ascii = 7'h43; // C
			8'h96: ascii = 7'h59; // Y
			8'h98: ascii = 7'h5A; // Z
			8'h9A: ascii = 7'h51; // Q
			8'hA0: ascii = 7'h35; // 5
			8'hA1: ascii = 7'h34; // 4
			8'hA3: ascii = 7'h33; // 3
			8'hA7: ascii = 7'h32; // 2
			8'hAF: ascii = 7'h31; // 1
			8'hB0: ascii = 7'h36; // 6
			8'hB8: ascii = 7'h37; // 7
			8'hBC: ascii = 7'h38; // 8
			8'hBE: ascii = 7'h39; // 9
			8'hBF: ascii = 7'h30; // 0
			default: ascii = mkd_pkg::CHAR_UNKNOWN;
		endcase
	end

endmodule

`default_nettype wire

@@ sv/mkd_core.sv @@
// Decoder core: press and silence counters, element buffer and gap detection.
// Computes one result per accepted tick. Depends on mkd_pkg, mkd_rom and
// morse_key_decoder_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "morse_key_decoder_assert.svh"

module mkd_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            accept,
	input  wire logic            key_down,
	input  wire mkd_pkg::cfg_t   cfg,
	output mkd_pkg::result_t     result
);

	mkd_pkg::cnt_t press_q, press_n;
	mkd_pkg::cnt_t silence_q, silence_n;
	logic [2:0]    elem_cnt_q, elem_cnt_n;
	logic [4:0]    elem_bits_q, elem_bits_n;
	logic          was_q, was_n;

	mkd_pkg::cnt_t dit_max_w, min_press_w, letter_gap_w, space_gap_w;
	mkd_pkg::cnt_t sil_base;
	logic [2:0]    cnt_take;
	logic [4:0]    bits_take;
	logic [6:0]    rom_ascii;

	assign dit_max_w    = mkd_pkg::cnt_t'(cfg.dit_max);
	assign min_press_w  = mkd_pkg::cnt_t'(cfg.min_press);
	assign letter_gap_w = mkd_pkg::cnt_t'(cfg.letter_gap);
	assign space_gap_w  = mkd_pkg::cnt_t'(cfg.space_gap);

	// Fold the press that just ended into the element buffer
	always_comb begin
		cnt_take  = elem_cnt_q;
		bits_take = elem_bits_q;
		sil_base  = silence_q;
		if (was_q) begin
			sil_base = '0;
			if (elem_cnt_q < mkd_pkg::MAX_ELEMENTS) begin
				if (press_q >= dit_max_w) begin
					bits_take = elem_bits_q | (5'b10000 >> elem_cnt_q);
					cnt_take  = elem_cnt_q + 3'd1;
				end else if (press_q > min_press_w) begin
					cnt_take = elem_cnt_q + 3'd1;
				end
			end
		end
	end

	mkd_rom u_rom (
		.pattern ({cnt_take, bits_take}),
		.ascii   (rom_ascii)
	);

	// Next state and result for this tick
	always_comb begin
		press_n     = press_q;
		silence_n   = silence_q;
		elem_cnt_n  = elem_cnt_q;
		elem_bits_n = elem_bits_q;
		was_n       = was_q;
		result      = '0;
		if (key_down) begin
			if (press_q != mkd_pkg::CNT_MAX) begin
				press_n = press_q + mkd_pkg::cnt_t'(1);
			end
			was_n      = 1'b1;
			result.led = (press_n >= dit_max_w);
		end else begin
			press_n     = '0;
			was_n       = 1'b0;
			elem_cnt_n  = cnt_take;
			elem_bits_n = bits_take;
			silence_n   = sil_base;
			if (sil_base != mkd_pkg::CNT_MAX) begin
				silence_n = sil_base + mkd_pkg::cnt_t'(1);
				if (silence_n == letter_gap_w && cnt_take != 3'd0) begin
					result.char_valid = 1'b1;
					result.char_code  = rom_ascii;
					elem_cnt_n        = '0;
					elem_bits_n       = '0;
				end else if (silence_n == space_gap_w) begin
					result.char_valid = 1'b1;
					result.char_code  = mkd_pkg::CHAR_SPACE;
				end
			end
		end
	end

	// Advance state on each accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_q     <= '0;
			silence_q   <= mkd_pkg::CNT_MAX;
			elem_cnt_q  <= '0;
			elem_bits_q <= '0;
			was_q       <= 1'b0;
		end else if (accept) begin
			press_q     <= press_n;
			silence_q   <= silence_n;
			elem_cnt_q  <= elem_cnt_n;
			elem_bits_q <= elem_bits_n;
			was_q       <= was_n;
		end
	end

	// Buffer never holds more than five elements
	`MKD_ASSERT_IMPL(a_elem_cnt_range, 1'b1, elem_cnt_q <= mkd_pkg::MAX_ELEMENTS)
	// A counted press always has its pressed flag set
	`MKD_ASSERT_IMPL(a_press_flag, press_q != '0, was_q)
	// The dash lamp only lights while the key is down
	`MKD_ASSERT_IMPL(a_led_key, accept && result.led, key_down)
	// A decoded letter empties the element buffer
	`MKD_ASSERT_NEXT(a_letter_clears,
		accept && result.char_valid && result.char_code != mkd_pkg::CHAR_SPACE,
		elem_cnt_q == 3'd0 && elem_bits_q == 5'd0)

endmodule

`default_nettype wire

@@ sv/morse_key_decoder.sv @@
// Morse straight-key decoder: one input beat per key sample tick, one result
// beat per input beat. The decode for a tick is combinational from the
// counter state, and the result sits in one output register, so a new tick is
// taken every clock as long as the output side drains.
// The result carries the dash lamp, and a character strobe with its ASCII code
// on the tick the silence counter reaches letter_gap (letter, '?' if unknown) or
// space_gap (space). Thresholds must be written through the configuration port
// only while no tick is in flight; the block does not enforce this. Indexes
// 0..3 select min_press, dit_max, letter_gap, space_gap; others are dropped.
// letter_gap must stay below space_gap. Depends on mkd_pkg and mkd_core.
`timescale 1ns / 1ps
`default_nettype none

module morse_key_decoder (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// key sample channel
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       key_down,
	// result channel
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            led,
	output logic            char_valid,
	output logic [6:0]      char_code,
	// configuration write channel
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [2:0] cfg_index,
	input  wire logic [7:0] cfg_data
);

	mkd_pkg::cfg_t    cfg_q;
	mkd_pkg::result_t res_comb;
	mkd_pkg::result_t res_q;
	logic             out_valid_q;
	logic             in_accept;

	// Take a beat unless a held result is blocked
	assign in_stall  = out_valid_q && out_stall;
	assign in_accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// Hold the timing thresholds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_press  <= 8'd3;
			cfg_q.dit_max    <= 8'd20;
			cfg_q.letter_gap <= 8'd30;
			cfg_q.space_gap  <= 8'd70;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mkd_pkg::REG_MIN_PRESS:  cfg_q.min_press  <= cfg_data;
				mkd_pkg::REG_DIT_MAX:    cfg_q.dit_max    <= cfg_data;
				mkd_pkg::REG_LETTER_GAP: cfg_q.letter_gap <= cfg_data;
				mkd_pkg::REG_SPACE_GAP:  cfg_q.space_gap  <= cfg_data;
				default: ;
			endcase
		end
	end

	mkd_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (in_accept),
		.key_down (key_down),
		.cfg      (cfg_q),
		.result   (res_comb)
	);

	// Output register: load on accept, drop when drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			res_q <= res_comb;
		end
	end

	assign out_valid  = out_valid_q;
	assign led        = res_q.led;
	assign char_valid = res_q.char_valid;
	assign char_code  = res_q.char_code;

endmodule

`default_nettype wire
